FILE: design/cprt_pkg.sv
// Shared constants and types for the contiguous prefix range tracker.
// Used by cprt_cell and contiguous_prefix_range_tracker_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cprt_pkg;

   localparam int OFFSET_WIDTH = 48;
   localparam int LENGTH_WIDTH = 21;
   // Wide enough to hold the largest legal chunk limit.
   localparam int CHUNK_WIDTH  = 25;

   localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

   localparam int PENDING_DEPTH_DEFAULT = 16;
   localparam int MAX_CHUNK_DEFAULT     = 1048576;

   // Stream payloads, padded to whole bytes.
   localparam int REQ_DATA_WIDTH = ((OFFSET_WIDTH + LENGTH_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((2 * OFFSET_WIDTH + 1 + 7) / 8) * 8;

   // Operation broadcast to every cell of the pending table.
   typedef struct packed {
      logic clear;   // drop every pending entry
      logic update;  // raise the end of the entry whose start matches
      logic insert;  // write the range into the first free cell
      logic drain;   // release the first entry that reaches the prefix
   } cmd_type;

   // Priority chain passed from each cell to its right-hand neighbor.
   typedef struct packed {
      logic free_seen;  // a free cell exists at or before this point
      logic hit_seen;   // a drainable cell exists at or before this point
   } link_type;

endpackage

`default_nettype wire

FILE: design/cprt_cell.sv
// One entry of the pending range table: start, end and valid flag, with its
// local compares and priority chain stage. Depends on cprt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cprt_cell (
   input  wire                                 clock,
   input  wire                                 reset,
   input  cprt_pkg::cmd_type                   cmd,
   input  wire  [cprt_pkg::OFFSET_WIDTH-1:0]   key_lo,
   input  wire  [cprt_pkg::OFFSET_WIDTH-1:0]   key_hi,
   input  wire  [cprt_pkg::OFFSET_WIDTH-1:0]   prefix,
   input  cprt_pkg::link_type                  link_in,
   output cprt_pkg::link_type                  link_out,
   output logic                                match,
   output logic [cprt_pkg::OFFSET_WIDTH-1:0]   take_end
);

   logic                              valid_ff, valid_in;
   logic [cprt_pkg::OFFSET_WIDTH-1:0] start_ff, start_in;
   logic [cprt_pkg::OFFSET_WIDTH-1:0] end_ff, end_in;
   logic                              hit, claim, take;

   assign match = valid_ff && (start_ff == key_lo);
   assign hit   = valid_ff && (start_ff <= prefix);
   // The first free cell in chain order takes a new range, and the first
   // reaching cell is the one released in a drain cycle.
   assign claim = !valid_ff && !link_in.free_seen;
   assign take  = hit && !link_in.hit_seen;

   assign link_out.free_seen = link_in.free_seen | !valid_ff;
   assign link_out.hit_seen  = link_in.hit_seen | hit;

   assign take_end = take ? end_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      end_in   = end_ff;
      priority if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.insert && claim) begin
         valid_in = 1'b1;
         start_in = key_lo;
         end_in   = key_hi;
      end else if (cmd.update && match && (key_hi > end_ff)) begin
         end_in = key_hi;
      end else if (cmd.drain && take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

endmodule

`default_nettype wire

FILE: design/contiguous_prefix_range_tracker_unit.sv
// Sequence: an accepted transaction enters ST_STORE; when the range is empty, too long or behind
// the prefix, it goes on to ST_FINISH, where its result is registered; else it passes through
// ST_DRAIN, which absorbs pending ranges (0 to PENDING_DEPTH), one per cycle by the chain.
// A new request is taken only after the last result is registered, which rsp_tready can hold
// back. Reset: synchronous, active high; the prefix returns to 0, the table empties, no result
// waits. A csr write, honored only in ST_IDLE, restarts the prefix and empties the table.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_prefix_range_tracker_unit #(
   parameter int PENDING_DEPTH = cprt_pkg::PENDING_DEPTH_DEFAULT,
   parameter int MAX_CHUNK     = cprt_pkg::MAX_CHUNK_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // Completed write ranges.
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // [47:0] range_offset, [68:48] range_length, [71:69] zero
   input  wire  [cprt_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // Prefix results, one per request.
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // [47:0] prefix_advance, [95:48] new_prefix, [96] table_full, [103:97] zero
   output logic [cprt_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // Start offset register.
   input  wire                                  csr_wen,
   input  wire  [cprt_pkg::OFFSET_WIDTH-1:0]    csr_wdata
);

   localparam int OW = cprt_pkg::OFFSET_WIDTH;
   localparam int LW = cprt_pkg::LENGTH_WIDTH;
   localparam int CW = cprt_pkg::CHUNK_WIDTH;

   // Sequencer states. The machine handles one transaction at a time: it
   // loads the range, applies it to the prefix or the table, then drains the
   // table one entry per cycle until no pending range reaches the prefix.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_STORE  = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [OW-1:0] prefix_ff, prefix_in;
   logic [OW-1:0] old_ff, old_in;
   logic [OW-1:0] lo_ff, lo_in;
   logic [OW-1:0] hi_ff, hi_in;
   logic          go_ff, go_in;
   logic          full_ff, full_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_advance_ff, rsp_prefix_ff;
   logic          rsp_full_ff;

   logic          req_accept;
   logic          rsp_load;
   logic [OW-1:0] req_offset;
   logic [LW-1:0] req_length;
   logic [OW:0]   range_sum;
   logic          length_ok;

   cprt_pkg::cmd_type  cmd;
   cprt_pkg::link_type links [PENDING_DEPTH+1];
   logic [PENDING_DEPTH-1:0] cell_match;
   logic [OW-1:0]            cell_end [PENDING_DEPTH];
   logic [OW-1:0]            drain_end;
   logic                     any_match, any_free, any_hit;

   // ------------------------------------------------------------------
   // Request decode. The range end saturates at the top of the offset space;
   // an empty range, or one longer than the chunk limit, is carried along
   // only to produce a zero-advance result.
   // ------------------------------------------------------------------
   assign req_offset = req_tdata[OW-1:0];
   assign req_length = req_tdata[OW+LW-1:OW];
   assign range_sum  = {1'b0, req_offset} + (OW+1)'(req_length);
   assign length_ok  = (req_length != '0) && (CW'(req_length) <= CW'(MAX_CHUNK));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // Pending table: a row of cells linked by a priority chain. Every cell
   // sees the same key and prefix; the chain picks the first free cell for
   // an insert and the first reaching cell for a drain.
   // ------------------------------------------------------------------
   assign links[0] = '{free_seen: 1'b0, hit_seen: 1'b0};

   for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
      cprt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .key_lo   (lo_ff),
         .key_hi   (hi_ff),
         .prefix   (prefix_ff),
         .link_in  (links[g]),
         .link_out (links[g+1]),
         .match    (cell_match[g]),
         .take_end (cell_end[g])
      );
   end

   assign any_match = |cell_match;
   assign any_free  = links[PENDING_DEPTH].free_seen;
   assign any_hit   = links[PENDING_DEPTH].hit_seen;

   // At most one cell drives a nonzero end, so an OR collects it.
   always_comb begin
      drain_end = '0;
      for (int i = 0; i < PENDING_DEPTH; i++) begin
         drain_end = drain_end | cell_end[i];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      prefix_in = prefix_ff;
      old_in    = old_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      go_in     = go_ff;
      full_in   = full_ff;
      cmd       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_wen) begin
               // New session: the prefix restarts at the written offset.
               prefix_in = csr_wdata;
               cmd.clear = 1'b1;
            end
            if (req_accept) begin
               lo_in    = req_offset;
               hi_in    = range_sum[OW] ? cprt_pkg::OFFSET_MAX : range_sum[OW-1:0];
               go_in    = length_ok;
               old_in   = prefix_ff;
               full_in  = 1'b0;
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (!go_ff || (hi_ff <= prefix_ff)) begin
               state_in = ST_FINISH;
            end else begin
               if (lo_ff <= prefix_ff) begin
                  prefix_in = hi_ff;
               end else begin
                  // Same start already pending: keep the larger end.
                  cmd.update = any_match;
                  cmd.insert = !any_match && any_free;
                  full_in    = !any_match && !any_free;
               end
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (any_hit) begin
               cmd.drain = 1'b1;
               if (drain_end > prefix_ff) begin
                  prefix_in = drain_end;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         prefix_ff <= '0;
      end else begin
         state_ff  <= state_in;
         prefix_ff <= prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      old_ff  <= old_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      go_ff   <= go_in;
      full_ff <= full_in;
   end

   // ------------------------------------------------------------------
   // Result register. It holds one finished transaction while the next
   // request is accepted and worked on.
   // ------------------------------------------------------------------
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_advance_ff <= prefix_ff - old_ff;
         rsp_prefix_ff  <= prefix_ff;
         rsp_full_ff    <= full_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = cprt_pkg::RSP_DATA_WIDTH'({rsp_full_ff, rsp_prefix_ff, rsp_advance_ff});

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
`ifndef ASSERT_OFF
   logic [PENDING_DEPTH-1:0] valid_map;

   for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_valid
      assign valid_map[g] = g_cell[g].u_cell.valid_ff;
   end

   // Without a start offset write, the prefix only grows.
   a_prefix_monotonic: assert property (@(posedge clock) disable iff (reset)
      !csr_wen |=> prefix_ff >= $past(prefix_ff))
      else $error("prefix moved backward");

   // Each drain cycle releases exactly one pending entry.
   a_drain_releases: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) && any_hit
      |=> $countones(valid_map) == $past($countones(valid_map)) - 1)
      else $error("drain cycle did not release one entry");

   // When a result is produced, no pending range reaches the prefix.
   a_drain_complete: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> !any_hit)
      else $error("pending range left undrained");

   // A dropped range is only reported with a completely full table.
   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      rsp_load && full_ff |-> !any_free)
      else $error("table_full reported with a free entry");
`endif

endmodule

`default_nettype wire
